/* hw/rtl/hover_height_pid_macros.svh */
// ----------------------------------------------------------------------------
// Hover height PID assertion macros
// Concurrent assertion helpers used by the hover height PID RTL.
// ----------------------------------------------------------------------------
`ifndef HOVER_HEIGHT_PID_MACROS_SVH
`define HOVER_HEIGHT_PID_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define HHP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define HHP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HHP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define HHP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* hw/rtl/hhp_pkg.sv */
// ----------------------------------------------------------------------------
// Hover height PID package
// Types and fixed constants of the hover height PID regulator.
// ----------------------------------------------------------------------------
package hhp_pkg;

  // Controller sequence.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_EDT,
    ST_INTEG,
    ST_DIV,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_I,
    ST_SUM,
    ST_OUT
  } state_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_KP     = 2'd0,
    REG_KI     = 2'd1,
    REG_KD     = 2'd2,
    REG_TARGET = 2'd3
  } reg_index_t;

  localparam logic [15:0] KP_RESET     = 16'd9600;
  localparam logic [15:0] KI_RESET     = 16'd800;
  localparam logic [15:0] KD_RESET     = 16'd2400;
  localparam logic [15:0] TARGET_RESET = 16'd9600;

  localparam int ERR_W   = 17;
  localparam int INTEG_W = 26;

  // +/-200.0 in Q9.16.
  localparam logic signed [INTEG_W-1:0] INTEGRAL_LIMIT = 26'sd13107200;

  // Timesteps below this code give a zero derivative.
  localparam logic [15:0] DT_MIN = 16'd7;

  // Divider: 34-bit dividend, two quotient bits per cycle.
  localparam int DIV_BITS   = 34;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CYCLES = DIV_BITS / DIV_STEPS;
  localparam int DIV_CNT_W  = 5;

endpackage

/* hw/rtl/hover_height_pid.sv */
// ----------------------------------------------------------------------------
// Hover height PID regulator
// Multi-point PID lift controller with clamped integral and state in RAM.
// ----------------------------------------------------------------------------
// A ground hit with a timestep of 7 codes or more steps through READ, EDT,
// INTEG, DIV, MUL_P, MUL_D, MUL_I, SUM and OUT; a smaller timestep skips DIV,
// and a miss or an unused point goes from READ straight to OUT. The divider
// for the derivative, two quotient bits per cycle, runs in DIV. A new item is
// taken only in IDLE, after OUT has loaded the result.
// Reset (rst, synchronous) restores the gains and target and clears every
// point's state through per-point valid bits.
`include "hover_height_pid_macros.svh"

module hover_height_pid #(
  parameter int NUM_POINTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] point_index, [17:2] measured_height, [33:18] time_step, [39:34] zero
  input  logic [39:0] s_axis_tdata,
  // [0] ground_hit
  input  logic        s_axis_tuser,
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] lift_force, [33:32] point_echo, [39:34] zero
  output logic [39:0] m_axis_tdata,
  // Configuration writes.
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import hhp_pkg::*;

  localparam int AW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

  // Configuration registers.
  logic [15:0] kp, ki, kd, target;

  // Control.
  state_t state, state_next;
  logic   s_fire;
  logic   out_load;

  // Item being worked on.
  logic [1:0]    cur_idx;
  logic          cur_hit;
  logic [15:0]   cur_height;
  logic [15:0]   cur_dt;
  logic [AW-1:0] cur_addr;
  logic          in_range;

  // Datapath registers.
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   prev_err;
  logic signed [INTEG_W-1:0] integ;
  logic signed [48:0]        prod;
  logic signed [60:0]        acc;
  logic signed [31:0]        deriv;
  logic [15:0]               rem;
  logic [DIV_BITS-1:0]       quo;
  logic [DIV_CNT_W-1:0]      div_cnt;
  logic                      diff_neg;

  // Per-point valid bits: an entry never written reads as zero.
  logic [(2**AW)-1:0] pt_valid;

  // Output register.
  logic [31:0] out_force;
  logic [1:0]  out_echo;

  // RAM ports.
  logic [AW+1:0]        rd_idx_ext;
  logic [AW-1:0]        rd_addr;
  logic                 ram_we;
  logic [INTEG_W-1:0]   integ_wr, integ_rd;
  logic [ERR_W-1:0]     prev_wr, prev_rd;

  // Shared multiplier.
  logic [15:0]        mul_a;
  logic signed [31:0] mul_b;
  logic signed [48:0] mul_p;

  // Combinational datapath values.
  logic signed [27:0]        isum;
  logic signed [27:0]        inc;
  logic signed [INTEG_W-1:0] integ_clamped;
  logic signed [17:0]        diff;
  logic [16:0]               diff_mag;
  logic [15:0]               rem_step;
  logic [DIV_BITS-1:0]       quo_step;
  logic                      dt_small;
  logic [31:0]               force_val;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_load = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);
  assign dt_small = (cur_dt < DT_MIN);

  assign m_axis_tdata = {6'd0, out_echo, out_force};

  // Point index widened, then cut to the RAM address width.
  assign rd_idx_ext  = {{AW{1'b0}}, s_axis_tdata[1:0]};
  assign rd_addr     = rd_idx_ext[AW-1:0];

  // ---------------------------------------------------------------------------
  // State memories: clamped integral (Q9.16) and previous error (Q10.6).
  // Only one item is in flight, and its write-back lands before the next
  // item's read, so no item uses an entry read while it was being written.
  // ---------------------------------------------------------------------------
  assign ram_we   = out_load && in_range;
  assign integ_wr = cur_hit ? integ : '0;
  assign prev_wr  = cur_hit ? err : {1'b0, target};

  hhp_ram #(
    .WIDTH (INTEG_W),
    .DEPTH (NUM_POINTS)
  ) u_integ_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cur_addr),
    .wr_data (integ_wr),
    .rd_addr (rd_addr),
    .rd_data (integ_rd)
  );

  hhp_ram #(
    .WIDTH (ERR_W),
    .DEPTH (NUM_POINTS)
  ) u_prev_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cur_addr),
    .wr_data (prev_wr),
    .rd_addr (rd_addr),
    .rd_data (prev_rd)
  );

  // ---------------------------------------------------------------------------
  // One 16-bit unsigned by 32-bit signed multiplier serves e*dt and the three PID terms.
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = cur_dt;
    mul_b = $signed({{15{err[ERR_W-1]}}, err});
    unique case (state)
      ST_MUL_P: mul_a = kp;
      ST_MUL_D: begin
        mul_a = kd;
        mul_b = deriv;
      end
      ST_MUL_I: begin
        mul_a = ki;
        mul_b = $signed({{6{integ[INTEG_W-1]}}, integ});
      end
      default: begin
        mul_a = cur_dt;
      end
    endcase
  end

  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  // Integral update: floor(e*dt / 64), add, clamp to +/-200.0.
  always_comb begin
    inc  = $signed(prod[33:6]);
    isum = $signed({{2{integ[INTEG_W-1]}}, integ}) + inc;
    if (isum > 28'(INTEGRAL_LIMIT)) begin
      integ_clamped = INTEGRAL_LIMIT;
    end else if (isum < -(28'(INTEGRAL_LIMIT))) begin
      integ_clamped = -INTEGRAL_LIMIT;
    end else begin
      integ_clamped = isum[INTEG_W-1:0];
    end
  end

  // Error difference for the derivative; its magnitude is divided by dt.
  assign diff     = $signed({err[ERR_W-1], err}) - $signed({prev_err[ERR_W-1], prev_err});
  assign diff_mag = diff[17] ? 17'(-diff) : diff[16:0];

  // Two restoring-division steps per cycle.
  always_comb begin
    logic [16:0] rs;
    logic [15:0] r;
    logic [DIV_BITS-1:0] q;
    r = rem;
    q = quo;
    for (int k = 0; k < DIV_STEPS; k++) begin
      rs = {r, q[DIV_BITS-1]};
      q  = {q[DIV_BITS-2:0], 1'b0};
      if (rs >= {1'b0, cur_dt}) begin
        rs   = rs - {1'b0, cur_dt};
        q[0] = 1'b1;
      end
      r = rs[15:0];
    end
    rem_step = r;
    quo_step = q;
  end

  // Positive sums are truncated to Q28.4 and saturated; the rest give zero.
  always_comb begin
    force_val = '0;
    if (in_range && cur_hit && !acc[60] && (acc != '0)) begin
      force_val = (|acc[60:48]) ? '1 : acc[47:16];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = (in_range && cur_hit) ? ST_EDT : ST_OUT;
      end
      ST_EDT:   state_next = ST_INTEG;
      ST_INTEG: state_next = dt_small ? ST_MUL_P : ST_DIV;
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          state_next = ST_MUL_P;
        end
      end
      ST_MUL_P: state_next = ST_MUL_D;
      ST_MUL_D: state_next = ST_MUL_I;
      ST_MUL_I: state_next = ST_SUM;
      ST_SUM:   state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Configuration registers; the user writes only while idle; unchecked here.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp     <= KP_RESET;
      ki     <= KI_RESET;
      kd     <= KD_RESET;
      target <= TARGET_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_KP:     kp     <= cfg_data;
        REG_KI:     ki     <= cfg_data;
        REG_KD:     kd     <= cfg_data;
        REG_TARGET: target <= cfg_data;
        default:    kp     <= kp;
      endcase
    end
  end

  // Control state: valid bits and the output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (ram_we) begin
        pt_valid[cur_addr] <= 1'b1;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (s_fire) begin
      cur_idx    <= s_axis_tdata[1:0];
      cur_height <= s_axis_tdata[17:2];
      cur_dt     <= s_axis_tdata[33:18];
      cur_hit    <= s_axis_tuser;
      cur_addr   <= rd_addr;
      in_range   <= (32'(s_axis_tdata[1:0]) < 32'(NUM_POINTS));
    end

    if (out_load) begin
      out_force <= force_val;
      out_echo  <= cur_idx;
    end

    unique case (state)
      ST_READ: begin
        // Entries never written since reset read as zero.
        integ    <= pt_valid[cur_addr] ? $signed(integ_rd) : '0;
        prev_err <= pt_valid[cur_addr] ? $signed(prev_rd) : '0;
        err      <= $signed({1'b0, target}) - $signed({1'b0, cur_height});
      end
      ST_EDT: begin
        prod     <= mul_p;
        diff_neg <= diff[17];
        rem      <= '0;
        quo      <= {1'b0, diff_mag, 16'd0};
        div_cnt  <= '0;
      end
      ST_INTEG: begin
        integ <= integ_clamped;
      end
      ST_DIV: begin
        rem     <= rem_step;
        quo     <= quo_step;
        div_cnt <= div_cnt + 1'b1;
      end
      ST_MUL_P: begin
        prod <= mul_p;
        if (dt_small) begin
          deriv <= '0;
        end else begin
          deriv <= diff_neg ? $signed(32'd0 - quo[31:0]) : $signed(quo[31:0]);
        end
      end
      ST_MUL_D: begin
        acc  <= $signed({{2{prod[48]}}, prod, 10'd0});
        prod <= mul_p;
      end
      ST_MUL_I: begin
        acc  <= acc + $signed({{2{prod[48]}}, prod, 10'd0});
        prod <= mul_p;
      end
      ST_SUM: begin
        acc <= acc + $signed({{12{prod[48]}}, prod});
      end
      default: begin
        div_cnt <= div_cnt;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `HHP_ASSERT_NEXT(a_accept_reads, clk, rst, s_fire, state == ST_READ, "accept did not start a read")
  `HHP_ASSERT_IMPLIES(a_integ_clamped, clk, rst, state == ST_MUL_P, (integ <= INTEGRAL_LIMIT) && (integ >= -INTEGRAL_LIMIT), "integral outside clamp")
  `HHP_ASSERT_IMPLIES(a_div_count, clk, rst, state == ST_DIV, div_cnt < DIV_CNT_W'(DIV_CYCLES), "divider overran")
  `HHP_ASSERT_NEXT(a_miss_zero, clk, rst, out_load && !(in_range && cur_hit), m_axis_tvalid && (out_force == '0), "miss gave nonzero force")

endmodule

/* hw/rtl/hhp_ram.sv */
// ----------------------------------------------------------------------------
// Hover height PID RAM
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module hhp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
